// ===== src/whole_word_substring_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property macros for the substring search core. Each use samples on
// clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WHOLE_WORD_SUBSTRING_SEARCH_CORE_DEFINES_SVH
`define WHOLE_WORD_SUBSTRING_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define WWSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WWSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wwss_pkg.sv =====
// ----------------------------------------------------------------------------
// wwss_pkg
// Types, constants and character helpers for the substring search core.
// ----------------------------------------------------------------------------
package wwss_pkg;

  localparam int PATTERN_MAX   = 32;
  localparam int POSITION_BITS = 20;
  localparam int CH_W          = 16;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W         = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CMD_W         = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 20;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // Commands.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHOLE_WORD   = 1'd1;

  // Characters.
  localparam logic [CH_W-1:0] CH_NUL     = 16'h0000;
  localparam logic [CH_W-1:0] CH_TAB     = 16'h0009;
  localparam logic [CH_W-1:0] CH_SPACE   = 16'h0020;
  localparam logic [CH_W-1:0] CH_APOS    = 16'h0027;
  localparam logic [CH_W-1:0] CH_COMMA   = 16'h002C;
  localparam logic [CH_W-1:0] CH_HYPHEN  = 16'h002D;
  localparam logic [CH_W-1:0] CH_PERIOD  = 16'h002E;
  localparam logic [CH_W-1:0] CH_COLON   = 16'h003A;
  localparam logic [CH_W-1:0] CH_SEMI    = 16'h003B;
  localparam logic [CH_W-1:0] CH_QUEST   = 16'h003F;
  localparam logic [CH_W-1:0] CH_UPPER_A = 16'h0041;
  localparam logic [CH_W-1:0] CH_UPPER_Z = 16'h005A;
  localparam logic [CH_W-1:0] CASE_DELTA = 16'h0020;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  ch;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic [POSITION_BITS-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] start_offset;
    logic                     whole_word;
  } cfg_t;

  function automatic logic [CH_W-1:0] fold(input logic [CH_W-1:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

  function automatic logic lead_sep(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_PERIOD) || (c == CH_TAB);
  endfunction

  function automatic logic trail_sep(input logic [CH_W-1:0] c);
    return lead_sep(c) || (c == CH_COLON) || (c == CH_SEMI) || (c == CH_HYPHEN) ||
           (c == CH_APOS) || (c == CH_QUEST) || (c == CH_NUL);
  endfunction

endpackage

// ===== src/whole_word_substring_search_core.sv =====
// ----------------------------------------------------------------------------
// whole_word_substring_search_core
// Case-insensitive substring search, whole-word when whole_word is set, over a stream of 16-bit
// characters, one report per text.
// ----------------------------------------------------------------------------
// Path: a request is registered in s1, matched combinationally, and its report is registered in the output register.
// Throughput: one request per cycle while out_stall does not hold a full output register; the shift-and update of all
// pattern positions for a character is combinational between input and result registers.
// Reset: synchronous active-low rst_n clears control and match state and sets
// whole_word to 1; the pattern store is not cleared and is valid once written.
module whole_word_substring_search_core
  import wwss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      s1_vld_r;
  in_item_t  s1_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  cfg_t      cfg_r;
  logic      out_free;
  logic      adv;
  logic      res_vld;
  out_item_t res;

  // The output register frees up when it is empty or being taken this cycle.
  assign out_free  = !out_vld_r || !out_stall;
  assign adv       = s1_vld_r && out_free;
  assign in_stall  = s1_vld_r && !out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_offset <= '0;
      cfg_r.whole_word   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_OFFSET: cfg_r.start_offset <= POSITION_BITS'(cfg_data);
        REG_WHOLE_WORD:   cfg_r.whole_word   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_item;
    end
  end

  wwss_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (adv),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_vld) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== src/wwss_match.sv =====
// ----------------------------------------------------------------------------
// wwss_match
// Pattern store and shift-and match state. Processes one request per cycle
// when go is high and produces at most one report for it.
// ----------------------------------------------------------------------------
`include "whole_word_substring_search_core_defines.svh"

module wwss_match
  import wwss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_vld,
  output out_item_t res
);

  logic [CH_W-1:0]          store_r [PATTERN_MAX];
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [PATTERN_MAX-1:0]   mv_r, mv_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     prev_sep_r, prev_sep_nxt;
  logic                     pend_r, pend_nxt;
  logic [POSITION_BITS-1:0] pstart_r, pstart_nxt;
  logic                     done_r, done_nxt;

  logic [CH_W-1:0]          c_fold;
  logic [PATTERN_MAX-1:0]   mask;
  logic [PATTERN_MAX-1:0]   mv_step;
  logic [LEN_W-1:0]         len_m1;
  logic [POSITION_BITS-1:0] back;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     inject;
  logic                     store_we;
  logic                     hit;
  logic [POSITION_BITS-1:0] hit_pos;
  logic                     restart;

  assign c_fold   = fold(item.ch);
  assign len_m1   = len_r - LEN_W'(1);
  assign back     = POSITION_BITS'(len_m1);
  assign start_pos = (pos_r >= back) ? pos_r - back : '0;
  assign inject   = (pos_r >= cfg.start_offset) && (!cfg.whole_word || prev_sep_r);
  assign mv_step  = ((mv_r << 1) | PATTERN_MAX'(inject)) & mask;
  assign store_we = go && (item.cmd == CMD_APPEND) && (len_r < LEN_W'(PATTERN_MAX));

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      mask[i] = (LEN_W'(i) < len_r) && (store_r[i] == c_fold);
    end
  end

  always_comb begin
    len_nxt      = len_r;
    mv_nxt       = mv_r;
    pos_nxt      = pos_r;
    prev_sep_nxt = prev_sep_r;
    pend_nxt     = pend_r;
    pstart_nxt   = pstart_r;
    done_nxt     = done_r;
    hit          = 1'b0;
    hit_pos      = '0;
    restart      = 1'b0;
    res_vld      = 1'b0;
    res.found    = 1'b0;
    res.position = '0;
    if (go) begin
      if (item.cmd == CMD_CLEAR || item.cmd == CMD_APPEND) begin
        if (item.cmd == CMD_CLEAR) begin
          len_nxt = '0;
        end else if (store_we) begin
          len_nxt = len_r + LEN_W'(1);
        end
        mv_nxt   = '0;
        pend_nxt = 1'b0;
      end else if (item.cmd == CMD_TEXT) begin
        if (done_r) begin
          restart = item.last;
        end else begin
          // A complete match waits one character to see what follows it.
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (trail_sep(item.ch)) begin
              hit     = 1'b1;
              hit_pos = pstart_r;
            end
          end
          if (!hit && len_r != '0) begin
            mv_nxt = mv_step;
            if (mv_step[len_m1[IDX_W-1:0]]) begin
              if (!cfg.whole_word || item.last) begin
                hit     = 1'b1;
                hit_pos = start_pos;
              end else begin
                pend_nxt   = 1'b1;
                pstart_nxt = start_pos;
              end
            end
          end
          prev_sep_nxt = lead_sep(item.ch);
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + POSITION_BITS'(1);
          end
          if (hit) begin
            done_nxt     = 1'b1;
            res_vld      = 1'b1;
            res.found    = 1'b1;
            res.position = hit_pos;
          end else if (item.last) begin
            res_vld = 1'b1;
          end
          restart = item.last;
        end
        if (restart) begin
          pos_nxt      = '0;
          mv_nxt       = '0;
          prev_sep_nxt = 1'b1;
          pend_nxt     = 1'b0;
          pstart_nxt   = '0;
          done_nxt     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[len_r[IDX_W-1:0]] <= c_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      mv_r       <= '0;
      pos_r      <= '0;
      prev_sep_r <= 1'b1;
      pend_r     <= 1'b0;
      pstart_r   <= '0;
      done_r     <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      mv_r       <= mv_nxt;
      pos_r      <= pos_nxt;
      prev_sep_r <= prev_sep_nxt;
      pend_r     <= pend_nxt;
      pstart_r   <= pstart_nxt;
      done_r     <= done_nxt;
    end
  end

  `WWSS_ASSERT_IMP(a_len_bound, 1'b1, len_r <= LEN_W'(PATTERN_MAX), "pattern length overflow")
  `WWSS_ASSERT_IMP(a_done_no_pend, done_r, !pend_r, "pending match after report")
  `WWSS_ASSERT_IMP(a_res_text, res_vld, go && item.cmd == CMD_TEXT, "report without text")
  `WWSS_ASSERT_NXT(a_last_restart, go && item.cmd == CMD_TEXT && item.last,
                   pos_r == '0 && !done_r && prev_sep_r, "text end did not restart")

endmodule
